/* hdl/ctpc_pkg.sv */
// ----------------------------------------------------------------------------
// ctpc_pkg
// Types, constants and table functions shared by the character to
// prefix-code transcoder.
// ----------------------------------------------------------------------------
package ctpc_pkg;

  localparam int CharW    = 8;
  localparam int SymW     = 5;
  localparam int PendW    = 7;
  localparam int CountW   = 3;
  localparam int LenW     = 4;
  localparam int StepW    = 3;
  localparam int PendMax  = 7;

  typedef struct packed {
    logic             kind;
    logic [CharW-1:0] char_in;
  } in_beat_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             is_line_end;
    logic             last;
  } out_beat_t;

  typedef struct packed {
    logic [PendW-1:0]  bits;
    logic [CountW-1:0] count;
  } pend_t;

  typedef struct packed {
    logic            hit;
    logic [SymW-1:0] sym;
  } sym_res_t;

  typedef struct packed {
    logic             hit;
    logic [CharW-1:0] ch;
  } match_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_FLUSH,
    ST_EOL
  } state_t;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  function automatic sym_res_t symbol_of(input logic [CharW-1:0] c);
    sym_res_t r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.hit = 1'b1;
      r.sym = SymW'(c - 8'h41);
    end else begin
      case (c)
        8'h20: r = '{hit: 1'b1, sym: 5'd26};
        8'h2E: r = '{hit: 1'b1, sym: 5'd27};
        8'h2C: r = '{hit: 1'b1, sym: 5'd28};
        8'h2D: r = '{hit: 1'b1, sym: 5'd29};
        8'h27: r = '{hit: 1'b1, sym: 5'd30};
        8'h3F: r = '{hit: 1'b1, sym: 5'd31};
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  function automatic match_res_t match_codeword(input logic [LenW-1:0] len,
                                                input logic [7:0] bits);
    match_res_t r;
    r.hit = 1'b1;
    r.ch  = '0;
    case ({len, bits})
      {4'd3, 8'h05}: r.ch = 8'h20;
      {4'd6, 8'h00}: r.ch = 8'h27;
      {4'd6, 8'h03}: r.ch = 8'h2C;
      {4'd8, 8'h91}: r.ch = 8'h2D;
      {4'd6, 8'h11}: r.ch = 8'h2E;
      {4'd6, 8'h01}: r.ch = 8'h3F;
      {4'd6, 8'h25}: r.ch = 8'h41;
      {4'd8, 8'h9A}: r.ch = 8'h42;
      {4'd4, 8'h05}: r.ch = 8'h43;
      {4'd4, 8'h01}: r.ch = 8'h44;
      {4'd3, 8'h06}: r.ch = 8'h45;
      {4'd5, 8'h09}: r.ch = 8'h46;
      {4'd8, 8'h9B}: r.ch = 8'h47;
      {4'd6, 8'h10}: r.ch = 8'h48;
      {4'd4, 8'h07}: r.ch = 8'h49;
      {4'd8, 8'h98}: r.ch = 8'h4A;
      {4'd4, 8'h06}: r.ch = 8'h4B;
      {4'd5, 8'h04}: r.ch = 8'h4C;
      {4'd8, 8'h99}: r.ch = 8'h4D;
      {4'd8, 8'h9E}: r.ch = 8'h4E;
      {4'd5, 8'h05}: r.ch = 8'h4F;
      {4'd3, 8'h07}: r.ch = 8'h50;
      {4'd8, 8'h9F}: r.ch = 8'h51;
      {4'd4, 8'h08}: r.ch = 8'h52;
      {4'd5, 8'h06}: r.ch = 8'h53;
      {4'd5, 8'h07}: r.ch = 8'h54;
      {4'd8, 8'h9C}: r.ch = 8'h55;
      {4'd8, 8'h9D}: r.ch = 8'h56;
      {4'd6, 8'h02}: r.ch = 8'h57;
      {4'd8, 8'h92}: r.ch = 8'h58;
      {4'd8, 8'h93}: r.ch = 8'h59;
      {4'd8, 8'h90}: r.ch = 8'h5A;
      default:       r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/char_to_prefix_code_transcoder_top.sv */
// ----------------------------------------------------------------------------
// char_to_prefix_code_transcoder_top
// Maps each letter or listed punctuation mark to a 5-bit symbol and decodes the symbol
// bits against a fixed prefix code, one code bit per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// A character beat is accepted and then runs five bit steps; a decoded
// character still held at the end is then flushed with last set. An
// end-of-line beat is accepted and then its line-end result is pushed. The
// five-step bit loop through the pending-bit state sets the rate. Reset is
// synchronous, active low; the state memory reads as empty until written.
// ----------------------------------------------------------------------------
module char_to_prefix_code_transcoder_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ctpc_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ctpc_pkg::out_beat_t  out_data
);

  ctpc_pkg::pend_t state_mem [1];
  ctpc_pkg::pend_t mem_rdata_r;
  logic            mem_valid_r;
  logic            mem_we;
  logic            mem_re;
  ctpc_pkg::pend_t mem_wdata;

  ctpc_pkg::state_t                  state_r, state_nxt;
  logic [ctpc_pkg::SymW-1:0]         sym_r, sym_nxt;
  logic [ctpc_pkg::StepW-1:0]        step_r, step_nxt;
  ctpc_pkg::pend_t                   work_r, work_nxt;
  logic                              held_valid_r, held_valid_nxt;
  logic [ctpc_pkg::CharW-1:0]        held_char_r, held_char_nxt;
  logic                              out_valid_r;
  ctpc_pkg::out_beat_t               out_data_r;

  logic                              can_push;
  logic                              push;
  ctpc_pkg::out_beat_t               push_data;
  ctpc_pkg::pend_t                   cur;
  logic                              cur_bit;
  logic [7:0]                        new_bits;
  logic [ctpc_pkg::LenW-1:0]         new_len;
  ctpc_pkg::match_res_t              mres;
  ctpc_pkg::sym_res_t                sres;
  logic                              in_acc;

  assign in_ready  = (state_r == ctpc_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign can_push  = !out_valid_r || out_ready;

  assign sres     = ctpc_pkg::symbol_of(in_data.char_in);
  assign cur      = (step_r == '0) ? mem_rdata_r : work_r;
  assign cur_bit  = sym_r[ctpc_pkg::SymW-1];
  assign new_bits = {cur.bits, cur_bit};
  assign new_len  = {1'b0, cur.count} + ctpc_pkg::LenW'(1);
  assign mres     = ctpc_pkg::match_codeword(new_len, new_bits);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      state_mem[0] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem_valid_r ? state_mem[0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_valid_r <= 1'b0;
    end else if (mem_we) begin
      mem_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ctpc_pkg::ST_IDLE;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      held_valid_r <= held_valid_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sym_r       <= sym_nxt;
    step_r      <= step_nxt;
    work_r      <= work_nxt;
    held_char_r <= held_char_nxt;
    if (push) begin
      out_data_r <= push_data;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    sym_nxt        = sym_r;
    step_nxt       = step_r;
    work_nxt       = work_r;
    held_valid_nxt = held_valid_r;
    held_char_nxt  = held_char_r;
    push           = 1'b0;
    push_data      = '0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_wdata      = '0;
    unique case (state_r)
      ctpc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.kind == ctpc_pkg::KIND_EOL) begin
            mem_we    = 1'b1;
            state_nxt = ctpc_pkg::ST_EOL;
          end else if (sres.hit) begin
            mem_re    = 1'b1;
            sym_nxt   = sres.sym;
            step_nxt  = '0;
            state_nxt = ctpc_pkg::ST_SHIFT;
          end
        end
      end
      ctpc_pkg::ST_SHIFT: begin
        if (!(mres.hit && held_valid_r && !can_push)) begin
          if (mres.hit) begin
            if (held_valid_r) begin
              push      = 1'b1;
              push_data = '{out_char: held_char_r, is_line_end: 1'b0, last: 1'b0};
            end
            held_valid_nxt = 1'b1;
            held_char_nxt  = mres.ch;
            work_nxt       = '0;
          end else if (new_len > ctpc_pkg::LenW'(ctpc_pkg::PendMax)) begin
            work_nxt = '0;
          end else begin
            work_nxt = '{bits: new_bits[ctpc_pkg::PendW-1:0],
                         count: new_len[ctpc_pkg::CountW-1:0]};
          end
          sym_nxt  = sym_r << 1;
          step_nxt = step_r + ctpc_pkg::StepW'(1);
          if (step_r == ctpc_pkg::StepW'(ctpc_pkg::SymW - 1)) begin
            mem_we    = 1'b1;
            mem_wdata = work_nxt;
            state_nxt = held_valid_nxt ? ctpc_pkg::ST_FLUSH : ctpc_pkg::ST_IDLE;
          end
        end
      end
      ctpc_pkg::ST_FLUSH: begin
        if (can_push) begin
          push           = 1'b1;
          push_data      = '{out_char: held_char_r, is_line_end: 1'b0, last: 1'b1};
          held_valid_nxt = 1'b0;
          state_nxt      = ctpc_pkg::ST_IDLE;
        end
      end
      ctpc_pkg::ST_EOL: begin
        if (can_push) begin
          push      = 1'b1;
          push_data = '{out_char: '0, is_line_end: 1'b1, last: 1'b1};
          state_nxt = ctpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ctpc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* bench/tb_char_to_prefix_code_transcoder_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_to_prefix_code_transcoder_top
// Self-checking bench for the character to prefix-code transcoder. A short
// directed run covers the alphabet edges, the skipped and dropped bytes and
// line ends; random text then runs under several idling mixes, with one long
// receiver hold-off. Every result beat is compared field by field with a
// prediction of the decoded text.
// ----------------------------------------------------------------------------

class decoded_text_board;
  ctpc_pkg::out_beat_t                expected_chars[$];
  logic [ctpc_pkg::PendW-1:0]         code_bits;
  logic [ctpc_pkg::CountW-1:0]        code_len;
  int                cw_len [32];
  logic [7:0]        cw_val [32];
  string             cw_chr;
  string             punct;
  int                errors;
  int                checked;
  int                line_ends;
  int                ignored;

  function new();
    cw_len = '{3, 6, 6, 8, 6, 6, 6, 8, 4, 4, 3, 5, 8, 6, 4, 8,
               4, 5, 8, 8, 5, 3, 8, 4, 5, 5, 8, 8, 6, 8, 8, 8};
    cw_val = '{8'h05, 8'h00, 8'h03, 8'h91, 8'h11, 8'h01, 8'h25, 8'h9A,
               8'h05, 8'h01, 8'h06, 8'h09, 8'h9B, 8'h10, 8'h07, 8'h98,
               8'h06, 8'h04, 8'h99, 8'h9E, 8'h05, 8'h07, 8'h9F, 8'h08,
               8'h06, 8'h07, 8'h9C, 8'h9D, 8'h02, 8'h92, 8'h93, 8'h90};
    cw_chr    = " ',-.?ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    punct     = " .,-'?";
    code_bits = '0;
    code_len  = '0;
    errors    = 0;
    checked   = 0;
    line_ends = 0;
    ignored   = 0;
  endfunction

  function int symbol_index(logic [7:0] c);
    int i;
    if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41;
    for (i = 0; i < 6; i++) begin
      if (punct[i] == c) return 26 + i;
    end
    return -1;
  endfunction

  function void note_char_beat(ctpc_pkg::in_beat_t beat);
    int                  sym;
    logic [4:0]          sym_bits;
    int                  b;
    int                  k;
    int                  len;
    logic [7:0]          word;
    bit                  found;
    bit                  have_held;
    ctpc_pkg::out_beat_t held;
    if (beat.kind == ctpc_pkg::KIND_EOL) begin
      code_bits = '0;
      code_len  = '0;
      expected_chars.insert(expected_chars.size(),
                            '{out_char: 8'h00, is_line_end: 1'b1, last: 1'b1});
      line_ends++;
      return;
    end
    sym = symbol_index(beat.char_in);
    if (beat.char_in == 8'h0A || beat.char_in == 8'h0D || sym < 0) begin
      ignored++;
      return;
    end
    sym_bits  = sym[4:0];
    have_held = 1'b0;
    held      = '0;
    for (b = 4; b >= 0; b--) begin
      word  = {code_bits, sym_bits[b]};
      len   = int'(code_len) + 1;
      found = 1'b0;
      for (k = 0; k < 32; k++) begin
        if (!found && cw_len[k] == len && cw_val[k] == word) begin
          found = 1'b1;
          if (have_held) expected_chars.insert(expected_chars.size(), held);
          held      = '{out_char: cw_chr[k], is_line_end: 1'b0, last: 1'b0};
          have_held = 1'b1;
        end
      end
      if (found || len > ctpc_pkg::PendMax) begin
        code_bits = '0;
        code_len  = '0;
      end else begin
        code_bits = word[ctpc_pkg::PendW-1:0];
        code_len  = ctpc_pkg::CountW'(len);
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      expected_chars.insert(expected_chars.size(), held);
    end
  endfunction

  function void check_decoded(ctpc_pkg::out_beat_t got);
    ctpc_pkg::out_beat_t want;
    if (expected_chars.size() == 0) begin
      errors++;
      $display("%0t: result beat with nothing expected: expected none, actual %h/%b/%b",
               $time, got.out_char, got.is_line_end, got.last);
      return;
    end
    want = expected_chars.pop_front();
    checked++;
    if (got.out_char !== want.out_char) begin
      errors++;
      $display("%0t: out_char mismatch: expected %h, actual %h",
               $time, want.out_char, got.out_char);
    end
    if (got.is_line_end !== want.is_line_end) begin
      errors++;
      $display("%0t: is_line_end mismatch: expected %b, actual %b",
               $time, want.is_line_end, got.is_line_end);
    end
    if (got.last !== want.last) begin
      errors++;
      $display("%0t: last mismatch: expected %b, actual %b",
               $time, want.last, got.last);
    end
  endfunction
endclass

module tb_char_to_prefix_code_transcoder_top;

  localparam int HoldCycles  = 300;
  localparam int QuietLimit  = 3000;
  localparam int SettleCycles = 10;
  localparam int TotalBeats  = 430;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  ctpc_pkg::in_beat_t  in_data;
  logic                out_valid;
  logic                out_ready;
  ctpc_pkg::out_beat_t out_data;

  decoded_text_board text_board;

  int idle_pct;
  int stall_pct;
  bit hold_req;
  bit hold_taken;
  int hold_left;
  int quiet_cycles;
  int beats_sent;

  char_to_prefix_code_transcoder_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    out_ready  = 1'b0;
    hold_taken = 1'b0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) text_board.check_decoded(out_data);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic [7:0] text_char();
    int    r;
    string punct;
    punct = " .,-'?";
    r = $urandom_range(31);
    if (r < 26) return 8'h41 + 8'(r);
    return punct[r-26];
  endfunction

  function automatic ctpc_pkg::in_beat_t random_beat();
    ctpc_pkg::in_beat_t b;
    int                 r;
    r         = $urandom_range(99);
    b.kind    = ctpc_pkg::KIND_CHAR;
    b.char_in = text_char();
    if (r >= 78 && r < 88) begin
      b.kind    = ctpc_pkg::KIND_EOL;
      b.char_in = 8'($urandom_range(255));
    end else if (r >= 88 && r < 92) begin
      b.char_in = ($urandom_range(1) != 0) ? 8'h0A : 8'h0D;
    end else if (r >= 92) begin
      b.char_in = 8'($urandom_range(255));
    end
    return b;
  endfunction

  task automatic send_beat(input ctpc_pkg::in_beat_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    text_board.note_char_beat(b);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_char(input logic [7:0] c);
    send_beat('{kind: ctpc_pkg::KIND_CHAR, char_in: c});
  endtask

  task automatic send_eol(input logic [7:0] c);
    send_beat('{kind: ctpc_pkg::KIND_EOL, char_in: c});
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (text_board.expected_chars.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic run_phase(input int beats, input int idle, input int stall);
    int goal;
    goal      = beats_sent + beats;
    idle_pct  = idle;
    stall_pct = stall;
    while (beats_sent < goal) send_beat(random_beat());
    pause_until_drained();
  endtask

  initial begin
    text_board   = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_req     = 1'b0;
    quiet_cycles = 0;
    beats_sent   = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_eol(8'h00);
    send_char("E");
    send_char("A");
    send_char("Z");
    send_char(" ");
    send_char(".");
    send_char(",");
    send_char("-");
    send_char("'");
    send_char("?");
    send_char(8'h0D);
    send_char(8'h0A);
    send_char("a");
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h80);
    send_char(8'h7F);
    send_char("Q");
    send_char("P");
    send_eol(8'hFF);
    send_char("M");
    send_char("J");
    send_eol(8'h00);
    pause_until_drained();

    hold_req = 1'b1;
    run_phase(100, 0, 0);
    run_phase(100, 64, 0);
    run_phase(100, 0, 64);
    run_phase(TotalBeats - beats_sent, 16, 16);

    repeat (20) @(negedge clk);
    $display("Sent %0d input beats (%0d line ends, %0d skipped or dropped), checked %0d results.",
             beats_sent, text_board.line_ends, text_board.ignored, text_board.checked);
    $display("Idling mixes: none, sender 64%%, receiver 64%%, both 16%%, plus one long hold-off.");
    if (text_board.errors == 0 && text_board.expected_chars.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/ctpc_pkg.sv
hdl/char_to_prefix_code_transcoder_top.sv
bench/tb_char_to_prefix_code_transcoder_top.sv
